FILE: rtl/two_level_masked_barrier_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-level masked barrier
// Clocked, reset-qualified property checks used by the top-level barrier file.
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_MASKED_BARRIER_ASSERT_SVH
`define TWO_LEVEL_MASKED_BARRIER_ASSERT_SVH

// Check an implication on every rising edge outside reset
`define TLMB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising edge, reset included
`define TLMB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tlmb_pkg.sv
// ---------------------------------------------------------------------------
// Two-level masked barrier package
// Shared constants and controller-to-datapath command type.
// ---------------------------------------------------------------------------
package tlmb_pkg;

    // Default cluster geometry
    localparam int CORE_COUNT_DEF = 16;
    localparam int TILE_COUNT_DEF = 4;

    // Field widths fixed by the interface
    localparam int CORE_ID_W = 4;
    localparam int LANE_MASK_W = 4;
    localparam int TILE_PART_W = 4;
    localparam int WAKE_W = 16;
    localparam int COUNT_W = 5;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TILE_PART = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_MODE = 1'b1;

    // Reset and limit values
    localparam logic [TILE_PART_W-1:0] TILE_PART_RESET = 4'hF;
    localparam logic [TILE_PART_W-1:0] TILE_PART_ALL = 4'hF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // Operation codes
    localparam logic OP_READ = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the accepted item
        logic commit;  // evaluate, update barrier state, load result
    } cmd_t;

endpackage

FILE: rtl/tlmb_ctrl.sv
// ---------------------------------------------------------------------------
// Barrier controller
// Sequences capture and evaluation of each item and owns the result valid.
// ---------------------------------------------------------------------------
module tlmb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output tlmb_pkg::cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Issue commands: evaluate only when the result slot is free or draining
    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        cmd.commit = (state_reg == S_EVAL) && (!out_valid_reg || !out_stall);
    end

    // Advance state and result valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/tlmb_datapath.sv
// ---------------------------------------------------------------------------
// Barrier datapath
// Per-tile arrival and mask tracking, cluster completion and result register.
// ---------------------------------------------------------------------------
module tlmb_datapath #(
    parameter int CORE_COUNT = tlmb_pkg::CORE_COUNT_DEF,
    parameter int TILE_COUNT = tlmb_pkg::TILE_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlmb_pkg::cmd_t                    cmd,
    input  logic [tlmb_pkg::CORE_ID_W-1:0]    core_id,
    input  logic                              op,
    input  logic [tlmb_pkg::LANE_MASK_W-1:0]  lane_mask,
    input  logic                              cfg_we,
    input  logic [tlmb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tlmb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              stalled,
    output logic                              released,
    output logic [tlmb_pkg::WAKE_W-1:0]       wake_cores,
    output logic [tlmb_pkg::COUNT_W-1:0]      arrival_count
);

    // Tiles collapse to one when they do not split the cores evenly
    localparam int EFF_TILES = ((CORE_COUNT % TILE_COUNT) == 0) ? TILE_COUNT : 1;
    localparam int LANES = CORE_COUNT / EFF_TILES;
    localparam int TW = (EFF_TILES > 1) ? $clog2(EFF_TILES) : 1;
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
    localparam int MW = LANES + tlmb_pkg::LANE_MASK_W;
    localparam int PW = EFF_TILES + tlmb_pkg::TILE_PART_W;
    localparam int WW = CORE_COUNT + tlmb_pkg::WAKE_W;

    // Captured item
    logic [tlmb_pkg::CORE_ID_W-1:0]   id_reg;
    logic                             op_reg;
    logic [tlmb_pkg::LANE_MASK_W-1:0] mask_reg;

    // Barrier state, flattened one bit per core or per tile
    logic [CORE_COUNT-1:0]            arrived_reg, arrived_next;
    logic [CORE_COUNT-1:0]            rmask_reg, rmask_next;
    logic [EFF_TILES-1:0]             open_reg, open_next;
    logic [EFF_TILES-1:0]             done_reg, done_next;
    logic [CORE_COUNT-1:0]            waiting_reg, waiting_next;
    logic [tlmb_pkg::COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [tlmb_pkg::TILE_PART_W-1:0] tpart_reg, tpart_next;
    logic                             cmode_reg, cmode_next;

    // Result register
    logic                             stalled_reg, stalled_next;
    logic                             released_reg, released_next;
    logic [tlmb_pkg::WAKE_W-1:0]      wake_reg, wake_next;
    logic [tlmb_pkg::COUNT_W-1:0]     count_reg, count_next;

    // Evaluation terms
    logic                             in_range;
    logic [TW-1:0]                    tile_idx;
    logic [LW-1:0]                    lane_idx;
    logic [CW-1:0]                    core_idx;
    int                               base;
    logic [LANES-1:0]                 lane_full;
    logic [MW-1:0]                    mask_wide;
    logic [LANES-1:0]                 mask_ext;
    logic [LANES-1:0]                 req;
    logic [LANES-1:0]                 tile_arr;
    logic [LANES-1:0]                 new_arr;
    logic [LANES-1:0]                 eff_mask;
    logic                             tile_open;
    logic                             tile_complete;
    logic [PW-1:0]                    tpart_wide;
    logic [EFF_TILES-1:0]             cmask;
    logic [EFF_TILES-1:0]             done_new;
    logic                             cluster_done;
    logic [tlmb_pkg::COUNT_W-1:0]     cnt_inc;
    logic [WW-1:0]                    wake_wide;

    // Decode the captured item against the current state
    always_comb
    begin
        in_range   = (32'(id_reg) < CORE_COUNT);
        // Find the tile by comparing against each tile's first core
        tile_idx   = '0;
        for (int t = 1; t < EFF_TILES; t++)
            if (32'(id_reg) >= t * LANES)
                tile_idx = TW'(t);
        core_idx   = CW'(id_reg);
        base       = int'(tile_idx) * LANES;
        lane_idx   = LW'(32'(id_reg) - base);
        lane_full  = '1;
        mask_wide  = {{LANES{1'b0}}, mask_reg};
        mask_ext   = mask_wide[LANES-1:0];
        req        = lane_full;
        if (op_reg == tlmb_pkg::OP_WRITE && mask_ext != '0)
        begin
            req = mask_ext;
        end
        if (cmode_reg)
        begin
            req = lane_full;
        end
        tile_arr      = arrived_reg[base +: LANES];
        tile_open     = open_reg[tile_idx];
        eff_mask      = tile_open ? rmask_reg[base +: LANES] : req;
        new_arr       = tile_arr | (LANES'(1) << lane_idx);
        tile_complete = ((new_arr & eff_mask) == eff_mask);
        tpart_wide    = {{EFF_TILES{1'b0}}, tpart_reg};
        cmask         = cmode_reg ? {EFF_TILES{1'b1}} : tpart_wide[EFF_TILES-1:0];
        done_new      = done_reg | (EFF_TILES'(1) << tile_idx);
        cluster_done  = tile_complete && ((done_new & cmask) == cmask);
        cnt_inc       = (cnt_reg == tlmb_pkg::COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        wake_wide     = {{tlmb_pkg::WAKE_W{1'b0}}, waiting_reg};
    end

    // Apply register writes, and on commit update barrier state and form the result
    always_comb
    begin
        arrived_next  = arrived_reg;
        rmask_next    = rmask_reg;
        open_next     = open_reg;
        done_next     = done_reg;
        waiting_next  = waiting_reg;
        cnt_next      = cnt_reg;
        tpart_next    = tpart_reg;
        cmode_next    = cmode_reg;
        stalled_next  = stalled_reg;
        released_next = released_reg;
        wake_next     = wake_reg;
        count_next    = count_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                tlmb_pkg::CFG_TILE_PART:  tpart_next = cfg_data[tlmb_pkg::TILE_PART_W-1:0];
                tlmb_pkg::CFG_COUNT_MODE: cmode_next = cfg_data[0];
            endcase
        end

        if (cmd.commit)
        begin
            stalled_next  = 1'b0;
            released_next = 1'b0;
            wake_next     = '0;
            count_next    = cnt_reg;
            if (in_range)
            begin
                if (cmode_reg)
                begin
                    tpart_next = tlmb_pkg::TILE_PART_ALL;
                end
                if (!tile_open)
                begin
                    rmask_next[base +: LANES] = req;
                    open_next[tile_idx]       = 1'b1;
                end
                if (!tile_complete)
                begin
                    // Tile still waiting on lanes
                    arrived_next[base +: LANES] = new_arr;
                    waiting_next[core_idx]      = 1'b1;
                    cnt_next                    = cnt_inc;
                    stalled_next                = 1'b1;
                    count_next                  = cnt_inc;
                end
                else
                begin
                    // Tile finished: clear its round and mark it done
                    arrived_next[base +: LANES] = '0;
                    open_next[tile_idx]         = 1'b0;
                    done_next                   = done_new;
                    if (!cluster_done)
                    begin
                        waiting_next[core_idx] = 1'b1;
                        cnt_next               = cnt_inc;
                        stalled_next           = 1'b1;
                        count_next             = cnt_inc;
                    end
                    else
                    begin
                        // Release every waiting core and drop the round
                        released_next = 1'b1;
                        wake_next     = wake_wide[tlmb_pkg::WAKE_W-1:0];
                        count_next    = '0;
                        cnt_next      = '0;
                        done_next     = '0;
                        waiting_next  = '0;
                    end
                end
            end
        end
    end

    // Hold barrier state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrived_reg <= '0;
            rmask_reg   <= '0;
            open_reg    <= '0;
            done_reg    <= '0;
            waiting_reg <= '0;
            cnt_reg     <= '0;
            tpart_reg   <= tlmb_pkg::TILE_PART_RESET;
            cmode_reg   <= 1'b0;
        end
        else
        begin
            arrived_reg <= arrived_next;
            rmask_reg   <= rmask_next;
            open_reg    <= open_next;
            done_reg    <= done_next;
            waiting_reg <= waiting_next;
            cnt_reg     <= cnt_next;
            tpart_reg   <= tpart_next;
            cmode_reg   <= cmode_next;
        end
    end

    // Capture the item and hold the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg   <= core_id;
            op_reg   <= op;
            mask_reg <= lane_mask;
        end
        stalled_reg  <= stalled_next;
        released_reg <= released_next;
        wake_reg     <= wake_next;
        count_reg    <= count_next;
    end

    assign stalled       = stalled_reg;
    assign released      = released_reg;
    assign wake_cores    = wake_reg;
    assign arrival_count = count_reg;

endmodule

FILE: rtl/two_level_masked_barrier.sv
// ---------------------------------------------------------------------------
// Two-level masked barrier
// Tile-level lane barriers feeding a cluster barrier over participating tiles.
// ---------------------------------------------------------------------------
// Each item is one core's barrier arrival and yields exactly one result item.
// An item is captured, then evaluated to update the per-tile arrival and mask
// bits; no new item is taken until the last one is evaluated. The result sits
// in an output register, so the next item is captured while an earlier result
// waits to be taken; evaluation holds only while that register is still full
// and stalled. Barrier state and configuration clear at reset, with no clearing
// pass; the captured item and result payload are not reset. The user must see
// that configuration is written through cfg_we, cfg_index and cfg_data while no item is in flight; unenforced.
module two_level_masked_barrier #(
    parameter int CORE_COUNT = tlmb_pkg::CORE_COUNT_DEF,
    parameter int TILE_COUNT = tlmb_pkg::TILE_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tlmb_pkg::CORE_ID_W-1:0]    core_id,
    input  logic                              op,
    input  logic [tlmb_pkg::LANE_MASK_W-1:0]  lane_mask,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              stalled,
    output logic                              released,
    output logic [tlmb_pkg::WAKE_W-1:0]       wake_cores,
    output logic [tlmb_pkg::COUNT_W-1:0]      arrival_count,
    input  logic                              cfg_we,
    input  logic [tlmb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tlmb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    `include "two_level_masked_barrier_assert.svh"

    tlmb_pkg::cmd_t cmd;

    // Sequence capture and evaluation
    tlmb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Track arrivals and form results
    tlmb_datapath #(
        .CORE_COUNT (CORE_COUNT),
        .TILE_COUNT (TILE_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .core_id       (core_id),
        .op            (op),
        .lane_mask     (lane_mask),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .stalled       (stalled),
        .released      (released),
        .wake_cores    (wake_cores),
        .arrival_count (arrival_count)
    );

    // A release never stalls the core and always closes the round count
    `TLMB_ASSERT(a_release_clears, out_valid && released |-> !stalled && arrival_count == '0, "release with stall or nonzero count")

    // Cores are woken only by a release
    `TLMB_ASSERT(a_wake_needs_release, out_valid && !released |-> wake_cores == '0, "wake without release")

    // An accepted item blocks the input until it is evaluated
    `TLMB_ASSERT(a_accept_blocks, in_valid && !in_stall |=> in_stall, "input open right after accept")

endmodule

FILE: tb/barrier_release_checker.sv
// ---------------------------------------------------------------------------
// Barrier release checker
// Watches the arrival, result and register channels of the two-level masked
// barrier, predicts each result from its own copy of the barrier state and
// compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module barrier_release_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [tlmb_pkg::CORE_ID_W-1:0]   core_id,
    input  logic                             op,
    input  logic [tlmb_pkg::LANE_MASK_W-1:0] lane_mask,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             stalled,
    input  logic                             released,
    input  logic [tlmb_pkg::WAKE_W-1:0]      wake_cores,
    input  logic [tlmb_pkg::COUNT_W-1:0]     arrival_count,
    input  logic                             cfg_we,
    input  logic [tlmb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tlmb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               outstanding,
    output int                               release_total
);

    // Cluster geometry; an uneven split collapses to a single tile
    localparam int TILES =
        (tlmb_pkg::CORE_COUNT_DEF % tlmb_pkg::TILE_COUNT_DEF == 0) ?
        tlmb_pkg::TILE_COUNT_DEF : 1;
    localparam int LANES = tlmb_pkg::CORE_COUNT_DEF / TILES;
    localparam logic [LANES-1:0] LANE_FULL = '1;
    localparam logic [TILES-1:0] TILE_FULL = '1;

    typedef struct packed {
        logic                         stalled;
        logic                         released;
        logic [tlmb_pkg::WAKE_W-1:0]  wake;
        logic [tlmb_pkg::COUNT_W-1:0] count;
    } outcome_t;

    // Register copies
    logic [tlmb_pkg::TILE_PART_W-1:0] tile_part;
    logic                             count_mode;

    // Barrier state copies
    logic [LANES-1:0]             lanes_arrived [TILES];
    logic [LANES-1:0]             round_mask    [TILES];
    logic                         round_open    [TILES];
    logic [TILES-1:0]             tiles_done;
    logic [tlmb_pkg::WAKE_W-1:0]  parked_set;
    logic [tlmb_pkg::COUNT_W-1:0] arrivals;

    outcome_t pending_outcomes[$];
    int       result_index;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                 result_index, what, got, want);
        fail_count++;
    endtask

    // Apply one core arrival to the barrier state and work out its outcome
    task automatic arrive_core(input logic [tlmb_pkg::CORE_ID_W-1:0] id,
                               input logic wr,
                               input logic [tlmb_pkg::LANE_MASK_W-1:0] mask_in,
                               output outcome_t res);
        int               t;
        int               lane;
        logic [LANES-1:0] req;
        logic [TILES-1:0] cluster_mask;
        res = '0;
        if (int'(id) >= tlmb_pkg::CORE_COUNT_DEF)
        begin
            res.count = arrivals;
            return;
        end
        t = int'(id) / LANES;
        lane = int'(id) % LANES;

        // Reads need the whole tile; a write with no lanes left means all lanes
        req = LANE_FULL;
        if (wr == tlmb_pkg::OP_WRITE)
        begin
            req = mask_in[LANES-1:0];
            if (req == '0)
                req = LANE_FULL;
        end
        if (count_mode)
        begin
            req = LANE_FULL;
            tile_part = tlmb_pkg::TILE_PART_ALL;
        end

        // First arrival of the tile round latches the mask
        if (!round_open[t])
        begin
            round_mask[t] = req;
            round_open[t] = 1'b1;
        end
        lanes_arrived[t][lane] = 1'b1;
        if (arrivals < tlmb_pkg::COUNT_MAX)
            arrivals++;

        if ((lanes_arrived[t] & round_mask[t]) != round_mask[t])
        begin
            parked_set[id] = 1'b1;
            res.stalled = 1'b1;
            res.count = arrivals;
            return;
        end

        // Tile complete: close its round and mark it done
        lanes_arrived[t] = '0;
        round_open[t] = 1'b0;
        tiles_done[t] = 1'b1;

        cluster_mask = count_mode ? TILE_FULL : tile_part[TILES-1:0];
        if ((tiles_done & cluster_mask) != cluster_mask)
        begin
            parked_set[id] = 1'b1;
            res.stalled = 1'b1;
            res.count = arrivals;
            return;
        end

        // Cluster complete: release everyone that was waiting
        res.released = 1'b1;
        res.wake = parked_set;
        res.count = '0;
        arrivals = '0;
        tiles_done = '0;
        parked_set = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            tile_part = tlmb_pkg::TILE_PART_RESET;
            count_mode = 1'b0;
            for (int t = 0; t < TILES; t++)
            begin
                lanes_arrived[t] = '0;
                round_mask[t] = '0;
                round_open[t] = 1'b0;
            end
            tiles_done = '0;
            parked_set = '0;
            arrivals = '0;
            pending_outcomes.delete();
            result_index = 0;
            fail_count = 0;
            outstanding = 0;
            release_total = 0;
        end
        else
        begin
            // Compare a returned result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got = '{stalled, released, wake_cores, arrival_count};
                if (pending_outcomes.size() == 0)
                begin
                    report_mismatch("result with nothing pending", 32'(got), 32'd0);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got.stalled !== want.stalled)
                        report_mismatch("stalled", 32'(got.stalled), 32'(want.stalled));
                    if (got.released !== want.released)
                        report_mismatch("released", 32'(got.released), 32'(want.released));
                    if (got.wake !== want.wake)
                        report_mismatch("wake_cores", 32'(got.wake), 32'(want.wake));
                    if (got.count !== want.count)
                        report_mismatch("arrival_count", 32'(got.count), 32'(want.count));
                    if (want.released)
                        release_total++;
                end
                result_index++;
            end

            // Track register writes
            if (cfg_we)
            begin
                if (cfg_index == tlmb_pkg::CFG_TILE_PART)
                    tile_part = cfg_data[tlmb_pkg::TILE_PART_W-1:0];
                else if (cfg_index == tlmb_pkg::CFG_COUNT_MODE)
                    count_mode = cfg_data[0];
            end

            // Predict the result of an accepted arrival
            if (in_valid && !in_stall)
            begin
                arrive_core(core_id, op, lane_mask, want);
                pending_outcomes.push_back(want);
            end
            outstanding = pending_outcomes.size();
        end
    end

endmodule

FILE: tb/two_level_masked_barrier_tb.sv
// ---------------------------------------------------------------------------
// Two-level masked barrier testbench
// Drives core arrivals and register writes into the barrier: a directed
// opening round, then random barrier rounds, noise and count-saturating runs
// under several register settings and three sender/receiver idling phases.
// A checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module two_level_masked_barrier_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEM_TARGET = 1150;
    localparam int SEGMENTS = 9;

    typedef struct packed {
        logic [tlmb_pkg::CORE_ID_W-1:0]   core;
        logic                             op;
        logic [tlmb_pkg::LANE_MASK_W-1:0] mask;
    } arrival_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [tlmb_pkg::CORE_ID_W-1:0]   core_id;
    logic                             op;
    logic [tlmb_pkg::LANE_MASK_W-1:0] lane_mask;
    logic                             out_valid;
    logic                             out_stall;
    logic                             stalled;
    logic                             released;
    logic [tlmb_pkg::WAKE_W-1:0]      wake_cores;
    logic [tlmb_pkg::COUNT_W-1:0]     arrival_count;
    logic                             cfg_we;
    logic [tlmb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tlmb_pkg::CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int outstanding;
    int release_total;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int settings_applied;
    int cycles;

    two_level_masked_barrier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .core_id       (core_id),
        .op            (op),
        .lane_mask     (lane_mask),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stalled       (stalled),
        .released      (released),
        .wake_cores    (wake_cores),
        .arrival_count (arrival_count),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    barrier_release_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .core_id       (core_id),
        .op            (op),
        .lane_mask     (lane_mask),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stalled       (stalled),
        .released      (released),
        .wake_cores    (wake_cores),
        .arrival_count (arrival_count),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .release_total (release_total)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Bound the run
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result receiver: stall at random at the current idle rate
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one arrival, idling first at random; hold it until accepted
    task automatic send_arrival(input arrival_t a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        core_id <= a.core;
        op <= a.op;
        lane_mask <= a.mask;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every result is back
    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Write both registers while the block is idle
    task automatic apply_setting(input logic [tlmb_pkg::TILE_PART_W-1:0] part,
                                 input logic counting);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= tlmb_pkg::CFG_TILE_PART;
        cfg_data <= part;
        @(negedge clk);
        cfg_index <= tlmb_pkg::CFG_COUNT_MODE;
        cfg_data <= {3'($urandom_range(7)), counting};
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // One barrier round: each chosen tile gets the lanes of its mask, at times a repeat, shuffled
    task automatic barrier_round;
        arrival_t                         plan[$];
        arrival_t                         tmp;
        logic                             wr;
        logic [tlmb_pkg::LANE_MASK_W-1:0] m;
        logic [tlmb_pkg::LANE_MASK_W-1:0] need;
        int                               k;
        for (int t = 0; t < 4; t++)
        begin
            if ($urandom_range(9) < 8)
            begin
                wr = 1'($urandom_range(1));
                m = ($urandom_range(4) == 0) ? 4'h0 : 4'($urandom_range(15));
                need = (wr == tlmb_pkg::OP_WRITE && m != 4'h0) ? m : 4'hF;
                for (int l = 0; l < 4; l++)
                    if (need[l])
                        plan.push_back('{4'(t * 4 + l), wr, m});
                if ($urandom_range(5) == 0)
                    plan.push_back('{4'(t * 4 + $urandom_range(3)), wr, m});
            end
        end
        for (int j = plan.size() - 1; j > 0; j--)
        begin
            k = $urandom_range(j);
            tmp = plan[j];
            plan[j] = plan[k];
            plan[k] = tmp;
        end
        foreach (plan[i])
            send_arrival(plan[i]);
    endtask

    // Opening round: repeat arrival, zero and partial masks, release on last
    arrival_t opening_round[11] = '{
        '{4'd0,  tlmb_pkg::OP_READ,  4'h0},
        '{4'd0,  tlmb_pkg::OP_READ,  4'hF},
        '{4'd5,  tlmb_pkg::OP_WRITE, 4'h0},
        '{4'd8,  tlmb_pkg::OP_WRITE, 4'h1},
        '{4'd15, tlmb_pkg::OP_WRITE, 4'h8},
        '{4'd1,  tlmb_pkg::OP_WRITE, 4'h6},
        '{4'd4,  tlmb_pkg::OP_READ,  4'h0},
        '{4'd6,  tlmb_pkg::OP_READ,  4'h0},
        '{4'd7,  tlmb_pkg::OP_WRITE, 4'hF},
        '{4'd2,  tlmb_pkg::OP_READ,  4'h0},
        '{4'd3,  tlmb_pkg::OP_READ,  4'h0}
    };

    // Register schedule for the random segments
    logic [tlmb_pkg::TILE_PART_W-1:0] part_plan[SEGMENTS] =
        '{4'hF, 4'h0, 4'h5, 4'hF, 4'hA, 4'h1, 4'h8, 4'h3, 4'hF};
    logic                             count_plan[SEGMENTS] =
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

    initial
    begin : stimulus
        arrival_t a;
        int       seg_goal;
        int       pick;
        int       runs;
        rst_n = 1'b0;
        in_valid = 1'b0;
        core_id = '0;
        op = tlmb_pkg::OP_READ;
        lane_mask = '0;
        cfg_we = 1'b0;
        cfg_index = tlmb_pkg::CFG_TILE_PART;
        cfg_data = '0;
        send_idle_pct = 30;
        recv_idle_pct = 56;
        items_sent = 0;
        settings_applied = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: one full round at reset settings
        foreach (opening_round[i])
            send_arrival(opening_round[i]);

        // No participating tiles: any tile completion releases
        apply_setting(4'h0, 1'b0);
        send_arrival('{4'd9, tlmb_pkg::OP_WRITE, 4'h2});

        // Counting mode forces full masks and overwrites participation
        apply_setting(4'h0, 1'b1);
        send_arrival('{4'd14, tlmb_pkg::OP_WRITE, 4'h4});
        drain();
        cfg_we <= 1'b1;
        cfg_index <= tlmb_pkg::CFG_COUNT_MODE;
        cfg_data <= 4'h0;
        @(negedge clk);
        cfg_we <= 1'b0;
        send_arrival('{4'd13, tlmb_pkg::OP_WRITE, 4'h2});
        send_arrival('{4'd12, tlmb_pkg::OP_READ, 4'h0});
        send_arrival('{4'd15, tlmb_pkg::OP_READ, 4'h0});

        // Random segments across three idling phases
        for (int s = 0; s < SEGMENTS; s++)
        begin
            if (s == 3)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 30;
            end
            else if (s == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting((s == 4) ? 4'($urandom_range(15)) : part_plan[s], count_plan[s]);
            seg_goal = items_sent + (ITEM_TARGET - items_sent) / (SEGMENTS - s);
            while (items_sent < seg_goal)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    barrier_round();
                end
                else if (pick < 92)
                begin
                    // Noise: fully random arrivals
                    runs = $urandom_range(1, 6);
                    repeat (runs)
                    begin
                        a = '{4'($urandom_range(15)), 1'($urandom_range(1)),
                              4'($urandom_range(15))};
                        send_arrival(a);
                    end
                end
                else if (pick < 96)
                begin
                    // Hammer one core with full-tile reads to saturate the count
                    a = '{4'($urandom_range(15)), tlmb_pkg::OP_READ,
                          4'($urandom_range(15))};
                    runs = $urandom_range(33, 38);
                    repeat (runs)
                        send_arrival(a);
                end
                else
                begin
                    // Broken round: a few lanes of one tile, never finished
                    a.op = tlmb_pkg::OP_WRITE;
                    a.mask = 4'hF;
                    runs = $urandom_range(1, 3);
                    pick = $urandom_range(3);
                    repeat (runs)
                    begin
                        a.core = 4'(pick * 4 + $urandom_range(3));
                        send_arrival(a);
                    end
                end
            end
        end

        // Let the last results come back, then a short tail for strays
        drain();
        repeat (8) @(negedge clk);
        $display("covered %0d arrivals under %0d register settings, %0d cluster releases",
                 items_sent, settings_applied, release_total);
        $display("three idling phases, count saturation runs and broken rounds included");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
